FILE: design/imh_pkg.sv
package imh_pkg;
	localparam int CAPACITY = 1024;
	localparam int VERTEX_COUNT = 1024;
	localparam int DIST_BITS = 32;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int VTX_W = 10;
	localparam int VA_W = $clog2(VERTEX_COUNT);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_DECREASE = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_ABSENT = 3'd3;
	localparam logic [2:0] ST_PRESENT = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_LOOKUP, S_DECIDE, S_EXT_RD, S_EXT_LAST,
		S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_L, S_DN_CMP, S_DONE
	} state_t;

	typedef struct packed {
		logic [VTX_W-1:0] vertex;
		logic [DIST_BITS-1:0] key;
	} slot_t;
endpackage

FILE: design/indexed_min_heap.sv
// Channel | Dir | tdata fields (low bit first)                     | tuser
// s_axis  | in  | operation[1:0] vertex[11:2] distance[43:12]      | -
// m_axis  | out | min_vertex[9:0] status[12:10] now_empty[13] count[24:14] | -
// One request at a time; a sift walks one heap level per pass through its states
// (up: S_UP_RD, S_UP_CMP; down: S_DN_RD, S_DN_L, S_DN_CMP) through the heap memory's
// one read and one write port. After reset a clearing pass sweeps all VERTEX_COUNT
// entries of the position map; no request is taken during it. The result waits in
// an output register until m_axis_tready.
module indexed_min_heap import imh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // operation, vertex, distance
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // min_vertex, status, now_empty, entry_count
);
	// Position map entry: valid bit plus slot index.
	typedef struct packed {
		logic vld;
		logic [IDX_W-1:0] idx;
	} pos_t;

	slot_t heap_mem [CAPACITY];
	pos_t pos_mem [VERTEX_COUNT];

	state_t state_q, state_d;
	logic [1:0] op_q;
	logic [VTX_W-1:0] vtx_q;
	logic [DIST_BITS-1:0] dist_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VA_W-1:0] clr_q;
	logic [IDX_W-1:0] idx_q;
	slot_t cur_q, best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic best_chg_q;
	logic [VTX_W-1:0] minv_q;
	logic [2:0] status_q;
	logic out_vld_q;

	// Memory ports, one read and one write each per cycle.
	logic h_re, h_we;
	logic [IDX_W-1:0] h_ra, h_wa;
	slot_t h_wd, h_rd;
	logic p_we;
	logic [VA_W-1:0] p_ra, p_wa;
	pos_t p_wd, p_rd;

	always_ff @(posedge clk) begin
		if (h_re) h_rd <= heap_mem[h_ra];
		if (h_we) heap_mem[h_wa] <= h_wd;
		p_rd <= pos_mem[p_ra];
		if (p_we) pos_mem[p_wa] <= p_wd;
	end

	logic [IDX_W:0] lchild, rchild;
	logic [IDX_W-1:0] parent;
	assign lchild = {idx_q, 1'b1};
	assign rchild = {idx_q, 1'b0} + (IDX_W+1)'(2);
	assign parent = (idx_q - 1'b1) >> 1;

	// Vertex identifiers at or above VERTEX_COUNT are treated as absent.
	logic vtx_oor;
	assign vtx_oor = {1'b0, vtx_q} >= (VTX_W+1)'(VERTEX_COUNT);

	// Sift-down choice: the right child wins only if strictly smaller than the best so far.
	logic dn_take_r, dn_move;
	logic [IDX_W-1:0] dn_sel_idx;
	slot_t dn_sel;
	assign dn_take_r = (CNT_W'(rchild) < cnt_q) && (h_rd.key < best_q.key);
	assign dn_move = best_chg_q || dn_take_r;
	assign dn_sel = dn_take_r ? h_rd : best_q;
	assign dn_sel_idx = dn_take_r ? rchild[IDX_W-1:0] : best_idx_q;

	assign s_axis_tready = (state_q == S_IDLE) && !out_vld_q;
	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == VA_W'(VERTEX_COUNT - 1)) state_d = S_IDLE;
			S_IDLE: if (acc) state_d = S_LOOKUP;
			S_LOOKUP: state_d = S_DECIDE;
			S_DECIDE: begin
				if (op_q == OP_INSERT) begin
					if (vtx_oor || p_rd.vld ||
					    cnt_q >= CNT_W'(CAPACITY)) state_d = S_DONE;
					else state_d = S_UP_RD;
				end else if (op_q == OP_EXTRACT) begin
					state_d = (cnt_q == '0) ? S_DONE : S_EXT_RD;
				end else if (op_q == OP_DECREASE) begin
					if (vtx_oor || !p_rd.vld ||
					    CNT_W'(p_rd.idx) >= cnt_q) state_d = S_DONE;
					else state_d = S_UP_RD;
				end else state_d = S_DONE;
			end
			S_EXT_RD: state_d = S_EXT_LAST;
			S_EXT_LAST: state_d = (cnt_q == '0) ? S_DONE : S_DN_RD;
			S_UP_RD: state_d = (idx_q == '0) ? S_DONE : S_UP_CMP;
			S_UP_CMP: state_d = (h_rd.key > cur_q.key) ? S_UP_RD : S_DONE;
			S_DN_RD: state_d = (CNT_W'(lchild) < cnt_q) ? S_DN_L : S_DONE;
			S_DN_L: state_d = S_DN_CMP;
			S_DN_CMP: state_d = dn_move ? S_DN_RD : S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		h_re = 1'b0; h_ra = '0; h_we = 1'b0; h_wa = '0; h_wd = cur_q;
		p_we = 1'b0; p_wa = vtx_q[VA_W-1:0]; p_wd = '{vld: 1'b1, idx: idx_q};
		p_ra = vtx_q[VA_W-1:0];
		unique case (state_q)
			S_CLEAR: begin
				p_we = 1'b1; p_wa = clr_q; p_wd = '0;
			end
			// The root is read early so that it is at hand for an extract.
			S_DECIDE: begin h_re = 1'b1; h_ra = '0; end
			S_EXT_RD: begin
				// Free the root's vertex and fetch the last entry.
				h_re = 1'b1; h_ra = IDX_W'(cnt_q - 1'b1);
				p_we = 1'b1; p_wa = h_rd.vertex[VA_W-1:0]; p_wd = '0;
			end
			S_UP_RD: begin
				// Park the moving entry and look at its parent.
				h_we = 1'b1; h_wa = idx_q; h_wd = cur_q; p_we = 1'b1;
				p_wa = cur_q.vertex[VA_W-1:0]; p_wd = '{vld: 1'b1, idx: idx_q};
				h_re = 1'b1; h_ra = parent;
			end
			S_UP_CMP: begin
				// Move the parent down into the hole.
				if (h_rd.key > cur_q.key) begin
					h_we = 1'b1; h_wa = idx_q; h_wd = h_rd; p_we = 1'b1;
					p_wa = h_rd.vertex[VA_W-1:0]; p_wd = '{vld: 1'b1, idx: idx_q};
				end
			end
			S_DN_RD: begin
				h_we = 1'b1; h_wa = idx_q; h_wd = cur_q; p_we = 1'b1;
				p_wa = cur_q.vertex[VA_W-1:0]; p_wd = '{vld: 1'b1, idx: idx_q};
				h_re = 1'b1; h_ra = lchild[IDX_W-1:0];
			end
			S_DN_L: begin h_re = 1'b1; h_ra = rchild[IDX_W-1:0]; end
			S_DN_CMP: begin
				// Move the smaller child up into the hole.
				if (dn_move) begin
					h_we = 1'b1; h_wa = idx_q; h_wd = dn_sel; p_we = 1'b1;
					p_wa = dn_sel.vertex[VA_W-1:0]; p_wd = '{vld: 1'b1, idx: idx_q};
				end
			end
			default: ;
		endcase
		if (state_q == S_DECIDE && op_q == OP_EXTRACT && cnt_q != '0) begin
			p_we = 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_axis_tvalid && m_axis_tready) out_vld_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: clr_q <= clr_q + 1'b1;
				S_IDLE: if (acc) begin
					op_q <= s_axis_tdata[1:0];
					vtx_q <= s_axis_tdata[11:2];
					dist_q <= s_axis_tdata[12 +: DIST_BITS];
					minv_q <= '0;
					status_q <= ST_OK;
				end
				S_LOOKUP: ;
				S_DECIDE: begin
					cur_q <= '{vertex: vtx_q, key: dist_q};
					if (op_q == OP_INSERT) begin
						if (vtx_oor) status_q <= ST_ABSENT;
						else if (p_rd.vld) status_q <= ST_PRESENT;
						else if (cnt_q >= CNT_W'(CAPACITY)) status_q <= ST_FULL;
						else begin
							idx_q <= IDX_W'(cnt_q);
							cnt_q <= cnt_q + 1'b1;
						end
					end else if (op_q == OP_EXTRACT) begin
						if (cnt_q == '0) status_q <= ST_EMPTY;
					end else if (op_q == OP_DECREASE) begin
						if (vtx_oor || !p_rd.vld ||
						    CNT_W'(p_rd.idx) >= cnt_q) status_q <= ST_ABSENT;
						else idx_q <= p_rd.idx;
					end
				end
				S_EXT_RD: begin
					// Root is in h_rd.
					minv_q <= h_rd.vertex;
					cnt_q <= cnt_q - 1'b1;
				end
				S_EXT_LAST: begin
					// Last entry moves to the root.
					cur_q <= h_rd;
					idx_q <= '0;
				end
				S_UP_RD: ;
				S_UP_CMP: begin
					if (h_rd.key > cur_q.key) idx_q <= parent;
				end
				S_DN_RD: begin
					best_q <= cur_q; best_chg_q <= 1'b0;
				end
				S_DN_L: begin
					if (h_rd.key < best_q.key) begin
						best_q <= h_rd; best_chg_q <= 1'b1;
						best_idx_q <= lchild[IDX_W-1:0];
					end
				end
				S_DN_CMP: begin
					if (dn_move) idx_q <= dn_sel_idx;
				end
				S_DONE: out_vld_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {7'd0, cnt_q, (cnt_q == '0), status_q, minv_q};

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY)) else $error("count over capacity");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> m_axis_tvalid) else $error("result lost");
endmodule
